// File: rtl/pdtmi_pkg.sv
`timescale 1ns / 1ps

package pdtmi_pkg;

  localparam int unsigned STAMP_W    = 39;
  localparam int unsigned PIPE_DEPTH = 10;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic       vld;
    stamp_t     stamp;
    logic [5:0] day;
    logic [6:0] mon;
    logic [6:0] yh;
    logic [6:0] yl;
    logic [6:0] hr;
    logic [6:0] mn;
  } pdtmi_fields_t;

  localparam logic [13:0] TEN_K   = 14'd10000;
  localparam logic [6:0]  HUNDRED = 7'd100;

  localparam logic [26:0] RECIP_1E4_W26 = 27'd109951163;
  localparam logic [27:0] RECIP_1E4_W27 = 28'd219902326;
  localparam logic [14:0] RECIP_100_W14 = 15'd20972;

  localparam stamp_t YEAR_ROLL   = 39'd301100002359;
  localparam stamp_t MON_ROLL_31 = 39'd300000002359;
  localparam stamp_t MON_ROLL_30 = 39'd290000002359;
  localparam stamp_t MON_ROLL_29 = 39'd280000002359;
  localparam stamp_t MON_ROLL_28 = 39'd270000002359;
  localparam stamp_t ONE_DAY     = 39'd10000000000;
  localparam stamp_t ONE_MONTH   = 39'd100000000;
  localparam stamp_t ONE_YEAR    = 39'd10000;
  localparam stamp_t DAY_ROLL    = 39'd2359;
  localparam stamp_t HOUR_STEP   = 39'd41;
  localparam stamp_t MINUTE_STEP = 39'd1;

  function automatic logic [12:0] div_1e4_w26(input logic [25:0] x);
    logic [52:0] p;
    p = 53'(x) * 53'(RECIP_1E4_W26);
    return p[52:40];
  endfunction

  function automatic logic [12:0] div_1e4_w27(input logic [26:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(RECIP_1E4_W27);
    return p[53:41];
  endfunction

  function automatic logic [6:0] div_100_w14(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(RECIP_100_W14);
    return p[27:21];
  endfunction

endpackage

// File: rtl/pdtmi_digits.sv
`timescale 1ns / 1ps

module pdtmi_digits (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  pdtmi_pkg::stamp_t        stamp_i,
  output pdtmi_pkg::pdtmi_fields_t fld_o
);
  import pdtmi_pkg::*;

  localparam int unsigned NSTG = 8;

  logic [NSTG:1] v_q;
  stamp_t        s_q [NSTG:1];

  logic [12:0] qa1_q, qa2_q, qa3_q;
  logic [26:0] t2_q, t3_q;
  logic [12:0] qt3_q;
  logic [25:0] u4_q, u5_q;
  logic [13:0] hhmm4_q, hhmm5_q;
  logic [12:0] du5_q, du6_q;
  logic [6:0]  hr5_q, hr6_q, hr7_q, hr8_q;
  logic [13:0] yr6_q, yr7_q;
  logic [6:0]  mn6_q, mn7_q, mn8_q;
  logic [5:0]  day6_q, day7_q, day8_q;
  logic [6:0]  mon7_q, mon8_q;
  logic [6:0]  yh7_q, yh8_q;
  logic [6:0]  yl8_q;

  logic [25:0] ra_w;
  logic [26:0] hhmm_w;
  logic [25:0] yr_w;
  logic [13:0] mn_w;
  logic [12:0] mon_w;
  logic [13:0] yl_w;

  assign ra_w   = s_q[1][38:13] - 26'(qa1_q) * 26'(TEN_K);
  assign hhmm_w = t3_q - 27'(qt3_q) * 27'(TEN_K);
  assign yr_w   = u5_q - 26'(du5_q) * 26'(TEN_K);
  assign mn_w   = hhmm5_q - 14'(hr5_q) * 14'(HUNDRED);
  assign mon_w  = du6_q - 13'(day6_q) * 13'(HUNDRED);
  assign yl_w   = yr7_q - 14'(yh7_q) * 14'(HUNDRED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NSTG-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[1] <= stamp_i;
    for (int i = 2; i <= NSTG; i++) begin
      s_q[i] <= s_q[i-1];
    end
    qa1_q   <= div_1e4_w26(stamp_i[38:13]);
    qa2_q   <= qa1_q;
    t2_q    <= {ra_w[13:0], s_q[1][12:0]};
    qa3_q   <= qa2_q;
    t3_q    <= t2_q;
    qt3_q   <= div_1e4_w27(t2_q);
    u4_q    <= {qa3_q, qt3_q};
    hhmm4_q <= hhmm_w[13:0];
    u5_q    <= u4_q;
    hhmm5_q <= hhmm4_q;
    du5_q   <= div_1e4_w26(u4_q);
    hr5_q   <= div_100_w14(hhmm4_q);
    du6_q   <= du5_q;
    yr6_q   <= yr_w[13:0];
    hr6_q   <= hr5_q;
    mn6_q   <= mn_w[6:0];
    day6_q  <= 6'(div_100_w14({1'b0, du5_q}));
    yr7_q   <= yr6_q;
    hr7_q   <= hr6_q;
    mn7_q   <= mn6_q;
    day7_q  <= day6_q;
    mon7_q  <= mon_w[6:0];
    yh7_q   <= div_100_w14(yr6_q);
    hr8_q   <= hr7_q;
    mn8_q   <= mn7_q;
    day8_q  <= day7_q;
    mon8_q  <= mon7_q;
    yh8_q   <= yh7_q;
    yl8_q   <= yl_w[6:0];
  end

  assign fld_o.vld   = v_q[NSTG];
  assign fld_o.stamp = s_q[NSTG];
  assign fld_o.day   = day8_q;
  assign fld_o.mon   = mon8_q;
  assign fld_o.yh    = yh8_q;
  assign fld_o.yl    = yl8_q;
  assign fld_o.hr    = hr8_q;
  assign fld_o.mn    = mn8_q;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_o.vld |-> (fld_o.mon < 7'd100) && (fld_o.yh < 7'd100) && (fld_o.yl < 7'd100) &&
                  (fld_o.hr < 7'd100) && (fld_o.mn < 7'd100))
    else $error("digit out of range");

  a_digit_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_o.vld |-> (64'(fld_o.stamp) ==
      64'(fld_o.day) * 64'd10000000000 + 64'(fld_o.mon) * 64'd100000000 +
      64'(fld_o.yh) * 64'd1000000 + 64'(fld_o.yl) * 64'd10000 +
      64'(fld_o.hr) * 64'd100 + 64'(fld_o.mn)))
    else $error("digits do not rebuild the stamp");

endmodule

// File: rtl/pdtmi_rollover.sv
`timescale 1ns / 1ps

module pdtmi_rollover (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdtmi_pkg::pdtmi_fields_t fld_i,
  output logic                     vld_o,
  output pdtmi_pkg::stamp_t        stamp_o
);
  import pdtmi_pkg::*;

  logic       eod;
  logic       leap;
  logic [4:0] last_day;
  stamp_t     delta_d;

  logic   v9_q, v10_q;
  stamp_t s9_q, delta9_q, sum10_q;

  assign eod  = (fld_i.hr == 7'd23) && (fld_i.mn == 7'd59);
  assign leap = ((fld_i.yl[1:0] == 2'd0) && (fld_i.yl != 7'd0)) ||
                ((fld_i.yl == 7'd0) && (fld_i.yh[1:0] == 2'd0));

  always_comb begin
    case (fld_i.mon) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: last_day = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    last_day = 5'd30;
      default:                                    last_day = leap ? 5'd29 : 5'd28;
    endcase
  end

  always_comb begin
    if (eod && (fld_i.mon == 7'd12) && (fld_i.day == 6'd31)) begin
      delta_d = ONE_YEAR - YEAR_ROLL;
    end else if (eod && (fld_i.day == {1'b0, last_day})) begin
      case (last_day)
        5'd31:   delta_d = ONE_MONTH - MON_ROLL_31;
        5'd30:   delta_d = ONE_MONTH - MON_ROLL_30;
        5'd29:   delta_d = ONE_MONTH - MON_ROLL_29;
        default: delta_d = ONE_MONTH - MON_ROLL_28;
      endcase
    end else if (eod) begin
      delta_d = ONE_DAY - DAY_ROLL;
    end else if (fld_i.mn == 7'd59) begin
      delta_d = HOUR_STEP;
    end else begin
      delta_d = MINUTE_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      v9_q  <= fld_i.vld;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_q     <= fld_i.stamp;
    delta9_q <= delta_d;
    sum10_q  <= s9_q + delta9_q;
  end

  assign vld_o   = v10_q;
  assign stamp_o = sum10_q;

  a_plain_minute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fld_i.vld && (fld_i.mn != 7'd59)) |=> (delta9_q == MINUTE_STEP))
    else $error("plain minute step not taken");

  a_sum_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v9_q |=> (sum10_q != $past(s9_q)))
    else $error("stamp did not advance");

endmodule

// File: rtl/packed_date_time_minute_increment.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       start high, busy low   stamp_in_i  [38:0]
// out      done_o (one cycle)     stamp_out_o [38:0]
//
// Each accepted beat yields its own done_o strobe, one beat per cycle.
// The pipe is the constant-reciprocal digit split (eight stages)
// and the rollover select and final add (two stages).
// Reset clears the valid bits only; payload registers hold whatever they had.
// busy stays low: the receiver cannot stall, so nothing ever holds the pipe.

module packed_date_time_minute_increment (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [38:0]              stamp_in_i,
  output logic                     done_o,
  output logic [38:0]              stamp_out_o
);
  import pdtmi_pkg::*;

  pdtmi_fields_t fld;
  logic          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pdtmi_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (accept),
    .stamp_i (stamp_in_i),
    .fld_o   (fld)
  );

  pdtmi_rollover u_rollover (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fld_i   (fld),
    .vld_o   (done_o),
    .stamp_o (stamp_out_o)
  );

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_DEPTH))
    else $error("result beat without an accepted input beat");

endmodule

// File: sim/packed_date_time_minute_increment_tb.sv
`timescale 1ns / 1ps

module packed_date_time_minute_increment_tb;
  import pdtmi_pkg::*;

  localparam int unsigned RANDOM_BEATS   = 1525;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 20;

  class stamp_board;
    localparam longint unsigned DAY_UNIT   = 64'd10000000000;
    localparam longint unsigned MONTH_UNIT = 64'd100000000;
    localparam longint unsigned YEAR_UNIT  = 64'd10000;
    localparam longint unsigned NEW_YEAR   = 64'd301100002359;
    localparam longint unsigned MIDNIGHT   = 64'd2359;

    stamp_t      pending_stamps[$];
    int unsigned mismatches = 0;

    static function int unsigned month_days(longint unsigned mon, longint unsigned yr);
      bit leap;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        default:               return leap ? 29 : 28;
      endcase
    endfunction

    static function stamp_t advance_minute(stamp_t s);
      longint unsigned v, day, mon, yr, hr, mn, last;
      bit              end_of_day;
      v          = 64'(s);
      day        = v / DAY_UNIT;
      mon        = (v / MONTH_UNIT) % 100;
      yr         = (v / YEAR_UNIT) % 10000;
      hr         = (v / 100) % 100;
      mn         = v % 100;
      last       = month_days(mon, yr);
      end_of_day = (hr == 23) && (mn == 59);
      if (end_of_day && mon == 12 && day == 31) begin
        v = v - NEW_YEAR + YEAR_UNIT;
      end else if (end_of_day && day == last) begin
        v = v - (last - 1) * DAY_UNIT - MIDNIGHT + MONTH_UNIT;
      end else if (end_of_day) begin
        v = v - MIDNIGHT + DAY_UNIT;
      end else if (mn == 59) begin
        v = v + 41;
      end else begin
        v = v + 1;
      end
      return stamp_t'(v);
    endfunction

    function void note_beat(stamp_t s);
      pending_stamps.push_back(advance_minute(s));
    endfunction

    task report_mismatch(string what, stamp_t got, stamp_t want);
      if (mismatches < 100)
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(stamp_t got);
      stamp_t want;
      if (pending_stamps.size() == 0) begin
        report_mismatch("result with no beat pending", got, '0);
      end else begin
        want = pending_stamps.pop_front();
        if (got !== want) report_mismatch("stamp_out mismatch", got, want);
      end
    endtask
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  stamp_t      stamp_in_i = '0;
  logic        busy;
  logic        done_o;
  stamp_t      stamp_out_o;
  int unsigned idle_cycles = 0;
  stamp_board  board = new();

  packed_date_time_minute_increment DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .stamp_in_i (stamp_in_i),
    .done_o     (done_o),
    .stamp_out_o(stamp_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_beat(stamp_in_i);
      if (done_o) board.check_result(stamp_out_o);
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("packed_date_time_minute_increment verification failed");
    $finish;
  end

  function automatic stamp_t pack_stamp(longint unsigned d, longint unsigned m,
                                        longint unsigned y, longint unsigned h,
                                        longint unsigned n);
    return stamp_t'(d * 64'd10000000000 + m * 64'd100000000 + y * 64'd10000 +
                    h * 64'd100 + n);
  endfunction

  function automatic stamp_t random_stamp();
    int unsigned kind, d, m, y, h, n, last;
    kind = $urandom_range(99);
    if (kind < 12) return stamp_t'({$urandom, $urandom});
    m = (kind < 22) ? $urandom_range(99) : $urandom_range(12, 1);
    case ($urandom_range(4))
      0:       y = $urandom_range(9999);
      1:       y = $urandom_range(99) * 100;
      2:       y = $urandom_range(24) * 400;
      3:       y = 9999;
      default: y = $urandom_range(2104, 1896);
    endcase
    last = stamp_board::month_days(m, y);
    case ($urandom_range(5))
      0, 1:    d = last;
      2:       d = last - 1;
      3:       d = (m == 12) ? 31 : $urandom_range(31, 1);
      4:       d = $urandom_range(31);
      default: d = (kind < 22) ? $urandom_range(54) : $urandom_range(31, 1);
    endcase
    if (kind < 22) begin
      h = $urandom_range(99);
      n = ($urandom_range(1) == 0) ? 59 : $urandom_range(99);
    end else begin
      h = ($urandom_range(2) == 0) ? $urandom_range(23) : 23;
      n = ($urandom_range(1) == 0) ? 59 : $urandom_range(59);
    end
    return pack_stamp(d, m, y, h, n);
  endfunction

  task automatic send_stamp(input stamp_t s, input bit may_idle);
    while (may_idle && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    stamp_in_i <= s;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_stamps.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stamp_t corner_stamps[$];
    corner_stamps.push_back('0);
    corner_stamps.push_back({39{1'b1}});
    corner_stamps.push_back(39'd319999999999);
    corner_stamps.push_back(pack_stamp(15, 6, 2023, 10, 30));
    corner_stamps.push_back(pack_stamp(15, 6, 2023, 10, 59));
    corner_stamps.push_back(pack_stamp(15, 6, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(31, 1, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(30, 4, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(31, 4, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(30, 11, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(28, 2, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(28, 2, 2024, 23, 59));
    corner_stamps.push_back(pack_stamp(29, 2, 2024, 23, 59));
    corner_stamps.push_back(pack_stamp(28, 2, 1900, 23, 59));
    corner_stamps.push_back(pack_stamp(29, 2, 2000, 23, 59));
    corner_stamps.push_back(pack_stamp(31, 12, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(31, 12, 9999, 23, 59));
    corner_stamps.push_back(pack_stamp(28, 0, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(29, 13, 2024, 23, 59));
    corner_stamps.push_back(pack_stamp(28, 99, 2023, 23, 59));
    corner_stamps.push_back(pack_stamp(0, 0, 0, 0, 59));
    corner_stamps.push_back(pack_stamp(31, 12, 2023, 22, 59));
    corner_stamps.push_back(pack_stamp(31, 12, 2023, 23, 58));
    corner_stamps.push_back(pack_stamp(54, 12, 9999, 99, 99));
    corner_stamps.push_back(pack_stamp(54, 98, 9999, 23, 59));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_stamps[i]) send_stamp(corner_stamps[i], 1'b1);

    // hold off idling for a long stretch, and drain once mid-run
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 1000) drain_results();
      send_stamp(random_stamp(), !(i >= 500 && i < 800));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_stamps.size() == 0) begin
      $display("packed_date_time_minute_increment verification clean");
    end else begin
      $display("packed_date_time_minute_increment verification failed");
    end
    $finish;
  end

endmodule

// File: packed_date_time_minute_increment.f
rtl/pdtmi_pkg.sv
rtl/pdtmi_digits.sv
rtl/pdtmi_rollover.sv
rtl/packed_date_time_minute_increment.sv
sim/packed_date_time_minute_increment_tb.sv
